[hdl/bfra_pkg.sv]
// Package for the best-fit ring allocator: field, command and state types,
// mode and status codes, and sizing constants. Depends on nothing.
package bfra_pkg;

   localparam int DEF_MAX_BLOCKS = 64;
   localparam int MAX_RESULTS    = 64;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_ALLOC = 2'd1;
   localparam logic [1:0] MODE_DUMP  = 2'd2;

   localparam logic [2:0] STATUS_EXACT  = 3'd0;
   localparam logic [2:0] STATUS_SPLIT  = 3'd1;
   localparam logic [2:0] STATUS_NOFIT  = 3'd2;
   localparam logic [2:0] STATUS_LISTED = 3'd3;
   localparam logic [2:0] STATUS_REJECT = 3'd4;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_ALLOC,
      OP_DUMP
   } op_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] block_label;
      logic [15:0] amount;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] block_label_res;
      logic [15:0] block_size;
      logic        last;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] block_label;
      logic [15:0] amount;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_slot_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DUMP_RD,
      S_DUMP_DATA,
      S_EMIT
   } state_type;

endpackage

[hdl/bfra_front.sv]
// Front stage of the allocator: takes requests, decodes the mode into a command
// and offers it to the command queue. Depends on bfra_pkg.
module bfra_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bfra_pkg::req_type      req_data,
   output bfra_pkg::cmd_slot_type push_slot,
   input  logic                   q_full
);
   import bfra_pkg::*;

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_cmd_ff, hold_cmd_in;
   cmd_type dec_cmd;
   logic    dec_keep;
   logic    accept;
   logic    pushed;

   // Mode 3 carries no work and is dropped here.
   always_comb begin
      dec_cmd.block_label = req_data.block_label;
      dec_cmd.amount      = req_data.amount;
      dec_cmd.op          = OP_LOAD;
      dec_keep            = 1'b1;
      case (req_data.mode)
         MODE_LOAD: begin
            dec_cmd.op = OP_LOAD;
         end
         MODE_ALLOC: begin
            dec_cmd.op = OP_ALLOC;
         end
         MODE_DUMP: begin
            dec_cmd.op = OP_DUMP;
         end
         default: begin
            dec_keep = 1'b0;
         end
      endcase
   end

   assign req_ready = !hold_valid_ff || !q_full;
   assign accept    = req_valid && req_ready;
   assign pushed    = hold_valid_ff && !q_full;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_cmd_in   = hold_cmd_ff;
      if (accept) begin
         hold_valid_in = dec_keep;
         hold_cmd_in   = dec_cmd;
      end else if (pushed) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_cmd_ff <= hold_cmd_in;
   end

   assign push_slot.valid = hold_valid_ff;
   assign push_slot.cmd   = hold_cmd_ff;

endmodule

[hdl/bfra_queue.sv]
// Short command queue between the front stage and the engine of the allocator.
// Depends on bfra_pkg.
module bfra_queue #(
   parameter int DEPTH = bfra_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bfra_pkg::cmd_slot_type push_slot,
   output logic                   q_full,
   output bfra_pkg::cmd_slot_type head_slot,
   input  logic                   q_pop
);
   import bfra_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   cmd_type          slots_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             do_push;

   assign q_full  = (count_ff == NW'(DEPTH));
   assign do_push = push_slot.valid && !q_full;

   assign head_slot.valid = (count_ff != '0);
   assign head_slot.cmd   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_slot.cmd;
      end
   end

endmodule

[hdl/bfra_engine.sv]
// Engine of the allocator: block memories, ring scan, removal shift, dump and
// the result register. Depends on bfra_pkg.
module bfra_engine #(
   parameter int MAX_BLOCKS = bfra_pkg::DEF_MAX_BLOCKS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bfra_pkg::cmd_slot_type head_slot,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bfra_pkg::rsp_type      rsp_data
);
   import bfra_pkg::*;

   localparam int IW  = $clog2(MAX_BLOCKS);
   localparam int CW  = $clog2(MAX_BLOCKS + 1);
   localparam int LIM = (MAX_BLOCKS < MAX_RESULTS) ? MAX_BLOCKS : MAX_RESULTS;
   localparam logic [CW-1:0] DUMP_LIM = CW'(LIM);
   localparam logic [CW-1:0] FULL_CNT = CW'(MAX_BLOCKS);

   logic [15:0] label_mem [MAX_BLOCKS];
   logic [15:0] size_mem  [MAX_BLOCKS];
   logic [15:0] label_rd_ff;
   logic [15:0] size_rd_ff;

   state_type     state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [IW-1:0] start_ff, start_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] lim_ff, lim_in;
   logic          found_ff, found_in;
   logic [15:0]   best_ff, best_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [15:0]   best_lab_ff, best_lab_in;
   logic [IW-1:0] rem_ff, rem_in;
   logic [IW-1:0] sh_ff, sh_in;
   logic          more_ff, more_in;
   rsp_type       res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff;

   logic [IW-1:0] rd_addr;
   logic          wr_lab_en;
   logic          wr_size_en;
   logic [IW-1:0] wr_addr;
   logic [15:0]   wr_label;
   logic [15:0]   wr_size;
   logic          rsp_load;
   logic          out_free;

   logic [CW-1:0] idx_inc;
   logic [IW-1:0] idx_wrap;
   logic [CW-1:0] cnt_inc;
   logic [CW-1:0] sh_inc;
   logic [CW-1:0] fill_dec;
   logic          exact;
   logic          fits;
   logic [15:0]   diff;
   logic          better;
   logic          found_nx;
   logic [15:0]   best_nx;
   logic [IW-1:0] best_idx_nx;
   logic [15:0]   best_lab_nx;
   logic          scan_done;
   logic          shift_go;
   logic          dump_last;

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign idx_inc   = CW'(idx_ff) + CW'(1);
   assign idx_wrap  = (idx_inc >= fill_ff) ? '0 : idx_inc[IW-1:0];
   assign cnt_inc   = cnt_ff + CW'(1);
   assign sh_inc    = CW'(sh_ff) + CW'(1);
   assign fill_dec  = fill_ff - CW'(1);
   assign exact     = (size_rd_ff == cmd_ff.amount);
   assign fits      = (cmd_ff.amount < size_rd_ff);
   assign diff      = size_rd_ff - cmd_ff.amount;
   assign better    = fits && (!found_ff || (diff < best_ff));
   assign found_nx  = found_ff || fits;
   assign best_nx     = better ? diff : best_ff;
   assign best_idx_nx = better ? idx_ff : best_idx_ff;
   assign best_lab_nx = better ? label_rd_ff : best_lab_ff;
   assign scan_done = (cnt_inc == fill_ff);
   assign shift_go  = (sh_inc < fill_ff);
   assign dump_last = (cnt_inc == lim_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (head_slot.valid) begin
               state_in = S_EMIT;
               if (head_slot.cmd.op == OP_ALLOC && fill_ff != '0) begin
                  state_in = S_SCAN_RD;
               end else if (head_slot.cmd.op == OP_DUMP && fill_ff != '0) begin
                  state_in = S_DUMP_RD;
               end
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (exact) begin
               state_in = S_SHIFT_RD;
            end else if (scan_done) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            state_in = shift_go ? S_SHIFT_WR : S_EMIT;
         end
         S_SHIFT_WR: begin
            state_in = S_SHIFT_RD;
         end
         S_DUMP_RD: begin
            state_in = S_DUMP_DATA;
         end
         S_DUMP_DATA: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = more_ff ? S_DUMP_RD : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop       = 1'b0;
      rd_addr     = idx_ff;
      wr_lab_en   = 1'b0;
      wr_size_en  = 1'b0;
      wr_addr     = sh_ff;
      wr_label    = label_rd_ff;
      wr_size     = size_rd_ff;
      rsp_load    = 1'b0;
      cmd_in      = cmd_ff;
      fill_in     = fill_ff;
      start_in    = start_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      lim_in      = lim_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      best_lab_in = best_lab_ff;
      rem_in      = rem_ff;
      sh_in       = sh_ff;
      more_in     = more_ff;
      res_in      = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (head_slot.valid) begin
               q_pop    = 1'b1;
               cmd_in   = head_slot.cmd;
               idx_in   = start_ff;
               cnt_in   = '0;
               found_in = 1'b0;
               more_in  = 1'b0;
               lim_in   = (fill_ff > DUMP_LIM) ? DUMP_LIM : fill_ff;
               res_in   = '{STATUS_REJECT, 16'd0, 16'd0, 1'b1};
               if (head_slot.cmd.op == OP_LOAD) begin
                  res_in = '{STATUS_REJECT, head_slot.cmd.block_label,
                             head_slot.cmd.amount, 1'b1};
                  if (fill_ff != FULL_CNT) begin
                     wr_lab_en  = 1'b1;
                     wr_size_en = 1'b1;
                     wr_addr    = fill_ff[IW-1:0];
                     wr_label   = head_slot.cmd.block_label;
                     wr_size    = head_slot.cmd.amount;
                     fill_in    = fill_ff + CW'(1);
                     res_in.status = STATUS_LISTED;
                  end
               end
            end
         end
         S_SCAN_CMP: begin
            if (exact) begin
               rem_in = idx_ff;
               sh_in  = idx_ff;
               res_in = '{STATUS_EXACT, label_rd_ff, 16'd0, 1'b1};
            end else begin
               found_in    = found_nx;
               best_in     = best_nx;
               best_idx_in = best_idx_nx;
               best_lab_in = best_lab_nx;
               cnt_in      = cnt_inc;
               idx_in      = idx_wrap;
               if (scan_done) begin
                  res_in = '{STATUS_NOFIT, 16'd0, 16'd0, 1'b1};
                  if (found_nx) begin
                     wr_size_en = 1'b1;
                     wr_addr    = best_idx_nx;
                     wr_size    = best_nx;
                     start_in   = best_idx_nx;
                     res_in     = '{STATUS_SPLIT, best_lab_nx, best_nx, 1'b1};
                  end
               end
            end
         end
         S_SHIFT_RD: begin
            if (shift_go) begin
               rd_addr = sh_inc[IW-1:0];
            end else begin
               fill_in  = fill_dec;
               start_in = (CW'(rem_ff) < fill_dec) ? rem_ff : '0;
            end
         end
         S_SHIFT_WR: begin
            wr_lab_en  = 1'b1;
            wr_size_en = 1'b1;
            sh_in      = sh_inc[IW-1:0];
         end
         S_DUMP_DATA: begin
            res_in  = '{STATUS_LISTED, label_rd_ff, size_rd_ff, dump_last};
            more_in = !dump_last;
            cnt_in  = cnt_inc;
            idx_in  = idx_wrap;
         end
         S_EMIT: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      lim_ff      <= lim_in;
      found_ff    <= found_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      best_lab_ff <= best_lab_in;
      rem_ff      <= rem_in;
      sh_ff       <= sh_in;
      more_ff     <= more_in;
      res_ff      <= res_in;
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_lab_en) begin
         label_mem[wr_addr] <= wr_label;
      end
      if (wr_size_en) begin
         size_mem[wr_addr] <= wr_size;
      end
      label_rd_ff <= label_mem[rd_addr];
      size_rd_ff  <= size_mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/best_fit_ring_allocator_top.sv]
// Top level of the best-fit ring allocator: front stage, command queue and
// engine. Depends on bfra_pkg, bfra_front, bfra_queue and bfra_engine.
//
//   channel  direction  payload             handshake
//   req      in         req_type            req_valid / req_ready
//   rsp      out        rsp_type            rsp_valid / rsp_ready
//
// A load is handled in the idle state. An allocation request reads and compares each
// block scanned, and when an exact match is removed, every later block is read and
// written one place down. A dump reads each listed block in turn.
// The pace is set by the single registered read port of the block memories.
// Reset clears the fill count, start position, queue and result valid flag; the
// memories are not cleared. The front stage and queue keep taking requests while
// the engine works or waits on rsp_ready, until the queue is full.
module best_fit_ring_allocator_top #(
   parameter int MAX_BLOCKS = bfra_pkg::DEF_MAX_BLOCKS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bfra_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bfra_pkg::rsp_type rsp_data
);
   import bfra_pkg::*;

   cmd_slot_type push_slot;
   cmd_slot_type head_slot;
   logic         q_full;
   logic         q_pop;

   bfra_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push_slot (push_slot),
      .q_full    (q_full)
   );

   bfra_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_slot (push_slot),
      .q_full    (q_full),
      .head_slot (head_slot),
      .q_pop     (q_pop)
   );

   bfra_engine #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .head_slot (head_slot),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // The engine only takes a command that the queue holds.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> head_slot.valid)
      else $error("engine popped an empty command queue");

   // A command waiting on a full queue is neither lost nor altered.
   assert property (@(posedge clock) disable iff (reset)
      push_slot.valid && q_full |=> push_slot.valid && $stable(push_slot.cmd))
      else $error("front stage dropped a stalled command");

   // Only dump entries can be followed by more results of the same request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.status == STATUS_LISTED)
      else $error("result without last mark that is not a dump entry");

   // Status codes stay within the defined set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= STATUS_REJECT)
      else $error("undefined status code");

endmodule

[tb/sv/tb_best_fit_ring_allocator_top.sv]
// Self-checking testbench for best_fit_ring_allocator_top. It predicts every
// response from its own copy of the free-block ring and checks each one in order.
// Depends on bfra_pkg and the allocator RTL.
module tb_best_fit_ring_allocator_top;
   import bfra_pkg::*;

   localparam int DEPTH = DEF_MAX_BLOCKS;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   class alloc_scoreboard;
      logic [15:0] labels [DEPTH];
      logic [15:0] sizes [DEPTH];
      int count;
      int start;
      rsp_type pending [$];
      int errors;

      function void remove_block(int r);
         for (int i = r; i + 1 < count; i++) begin
            labels[i] = labels[i + 1];
            sizes[i] = sizes[i + 1];
         end
         count--;
         start = (r < count) ? r : 0;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         int idx;
         int best_idx;
         int n;
         bit found;
         logic [15:0] best;
         if (start >= count) start = 0;
         e = '{STATUS_REJECT, 16'h0, 16'h0, 1'b1};
         case (r.mode)
            MODE_LOAD: begin
               if (count >= DEPTH) begin
                  e.block_label_res = r.block_label;
                  e.block_size = r.amount;
               end else begin
                  labels[count] = r.block_label;
                  sizes[count] = r.amount;
                  count++;
                  e = '{STATUS_LISTED, r.block_label, r.amount, 1'b1};
               end
               pending.push_back(e);
            end
            MODE_ALLOC: begin
               if (count != 0) begin
                  idx = start;
                  found = 1'b0;
                  best = 16'h0;
                  best_idx = 0;
                  for (int k = 0; k < count; k++) begin
                     if (sizes[idx] == r.amount) begin
                        e = '{STATUS_EXACT, labels[idx], 16'h0, 1'b1};
                        remove_block(idx);
                        pending.push_back(e);
                        return;
                     end
                     if (r.amount < sizes[idx] && (!found || sizes[idx] - r.amount < best)) begin
                        found = 1'b1;
                        best = sizes[idx] - r.amount;
                        best_idx = idx;
                     end
                     idx = (idx + 1 >= count) ? 0 : idx + 1;
                  end
                  if (found) begin
                     sizes[best_idx] = best;
                     start = best_idx;
                     e = '{STATUS_SPLIT, labels[best_idx], best, 1'b1};
                  end else begin
                     e = '{STATUS_NOFIT, 16'h0, 16'h0, 1'b1};
                  end
               end
               pending.push_back(e);
            end
            MODE_DUMP: begin
               if (count == 0) begin
                  pending.push_back(e);
               end else begin
                  n = (count > MAX_RESULTS) ? MAX_RESULTS : count;
                  idx = start;
                  for (int k = 0; k < n; k++) begin
                     pending.push_back('{STATUS_LISTED, labels[idx], sizes[idx],
                                         (k + 1 == n) ? 1'b1 : 1'b0});
                     idx = (idx + 1 >= count) ? 0 : idx + 1;
                  end
               end
            end
            default: begin
            end
         endcase
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $error("response with nothing outstanding: status %0d label 0x%0h size 0x%0h",
                   got.status, got.block_label_res, got.block_size);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare_field("status", 16'(want.status), 16'(got.status));
         compare_field("block_label_res", want.block_label_res, got.block_label_res);
         compare_field("block_size", want.block_size, got.block_size);
         compare_field("last", 16'(want.last), 16'(got.last));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic no_idle = 1'b0;
   alloc_scoreboard book = new();

   best_fit_ring_allocator_top #(.MAX_BLOCKS(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 30);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) book.check_result(rsp_data);
   end

   task automatic send_request(input req_type r);
      if (!no_idle) begin
         while ($urandom_range(0, 99) < 30) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      book.note_request(r);
   endtask

   task automatic send_fields(input logic [1:0] m, input logic [15:0] l, input logic [15:0] a);
      send_request('{m, l, a});
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (book.pending.size() != 0);
   endtask

   function automatic req_type random_request();
      req_type r;
      int pick;
      int k;
      logic [15:0] sz;
      r.block_label = 16'($urandom);
      r.amount = 16'($urandom_range(1, 40));
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, 19);
      if (pick < 35) begin
         r.mode = MODE_LOAD;
         if (k < 2) r.amount = 16'h0;
         else if (k < 4) r.amount = 16'($urandom);
      end else if (pick < 82) begin
         r.mode = MODE_ALLOC;
         sz = (book.count > 0) ? book.sizes[$urandom_range(0, book.count - 1)] : 16'h0;
         if (book.count > 0 && k < 8) r.amount = sz;
         else if (book.count > 0 && k < 15 && sz != 0)
            r.amount = sz - 16'($urandom_range(1, (sz < 5) ? sz : 5));
         else if (k < 18) r.amount = 16'($urandom);
         else r.amount = 16'hFFFF;
      end else if (pick < 95) begin
         r.mode = MODE_DUMP;
      end else begin
         r.mode = MODE_UNUSED;
      end
      return r;
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_fields(MODE_ALLOC, 16'h0000, 16'd5);
      send_fields(MODE_DUMP, 16'h0000, 16'h0000);
      send_fields(MODE_UNUSED, 16'hFFFF, 16'hFFFF);
      send_fields(MODE_LOAD, 16'h0000, 16'h0000);
      send_fields(MODE_LOAD, 16'hFFFF, 16'hFFFF);
      send_fields(MODE_ALLOC, 16'h0000, 16'hFFFF);
      send_fields(MODE_ALLOC, 16'hFFFF, 16'h0000);
      send_fields(MODE_DUMP, 16'h0000, 16'h0000);
      send_fields(MODE_LOAD, 16'h1111, 16'd20);
      send_fields(MODE_LOAD, 16'h2222, 16'd30);
      send_fields(MODE_LOAD, 16'h3333, 16'd20);
      send_fields(MODE_LOAD, 16'h4444, 16'd50);
      send_fields(MODE_ALLOC, 16'h0000, 16'd10);
      send_fields(MODE_ALLOC, 16'h0000, 16'd15);
      send_fields(MODE_DUMP, 16'h0000, 16'h0000);
      send_fields(MODE_ALLOC, 16'h0000, 16'd60);
      send_fields(MODE_ALLOC, 16'h0000, 16'd10);
      send_fields(MODE_ALLOC, 16'h0000, 16'd30);
      send_fields(MODE_DUMP, 16'h0000, 16'h0000);
      send_fields(MODE_ALLOC, 16'h0000, 16'hFFFF);

      while (book.count < DEPTH)
         send_fields(MODE_LOAD, 16'($urandom), 16'($urandom_range(1, 40)));
      send_fields(MODE_LOAD, 16'hFFFF, 16'hFFFF);
      send_fields(MODE_LOAD, 16'($urandom), 16'($urandom));
      send_fields(MODE_DUMP, 16'h0000, 16'h0000);
      wait_drained();

      for (int i = 0; i < 175; i++) begin
         no_idle <= (i >= 40 && i < 90);
         send_request(random_request());
      end
      no_idle <= 1'b0;
      wait_drained();
      repeat (300) @(posedge clock);

      if (book.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule

[filelist.f]
hdl/bfra_pkg.sv
hdl/bfra_front.sv
hdl/bfra_queue.sv
hdl/bfra_engine.sv
hdl/best_fit_ring_allocator_top.sv
tb/sv/tb_best_fit_ring_allocator_top.sv
